>>> hw/rtl/ppfla_pkg.sv
// shared types and constants for the per-pool free list allocator
package ppfla_pkg;

    localparam int NUM_POOLS      = 4;
    localparam int SLOTS_PER_POOL = 64;

    localparam int POOL_FIELD_W = 2;
    localparam int SLOT_FIELD_W = 6;

    localparam int POOL_IDX_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int HEAD_W     = $clog2(SLOTS_PER_POOL + 1);
    localparam int LINK_DEPTH = NUM_POOLS * SLOTS_PER_POOL;
    localparam int LINK_ADDR_W = $clog2(LINK_DEPTH);

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_e;

    typedef enum logic [0:0] {
        STATUS_GRANTED = 1'b0,
        STATUS_EMPTY   = 1'b1
    } status_e;

    typedef struct packed {
        cmd_e                     command;
        logic [POOL_FIELD_W-1:0]  pool_id;
        logic [SLOT_FIELD_W-1:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        status_e                  status;
        logic [SLOT_FIELD_W-1:0]  granted_slot;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept_alloc;
        logic accept_free;
        logic finish_alloc;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

>>> hw/rtl/ppfla_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ppfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ppfla_ctrl.sv
// controller state machine: sequences free and allocate transfers
module ppfla_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ppfla_pkg::cmd_e       command,
    input  logic                  out_ready,
    input  ppfla_pkg::dp_status_t sts,
    output ppfla_pkg::dp_cmd_t    cmd
);
    import ppfla_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LINK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready         = (state_reg == S_IDLE);
        cmd.accept_alloc = in_valid && in_ready && (command == CMD_ALLOC);
        cmd.accept_free  = in_valid && in_ready && (command == CMD_FREE);
        // link data is ready; hand result over once the output register frees up
        cmd.finish_alloc = (state_reg == S_LINK) && (!sts.out_full || out_ready);
        state_next       = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept_alloc)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                if (cmd.finish_alloc)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/ppfla_dp.sv
// datapath: pool heads, link memory with valid bits, output register
module ppfla_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppfla_pkg::in_item_t   in_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output ppfla_pkg::out_item_t  out_data,
    input  ppfla_pkg::dp_cmd_t    cmd,
    output ppfla_pkg::dp_status_t sts
);
    import ppfla_pkg::*;

    logic [HEAD_W-1:0]      head_reg [NUM_POOLS];
    logic [LINK_DEPTH-1:0]  link_valid_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    // alloc context held across the link read
    logic [POOL_IDX_W-1:0]  pool_q;
    logic                   hit_q;
    logic [HEAD_W-1:0]      head_q;
    logic                   valid_q;
    logic [HEAD_W-1:0]      dflt_q;

    logic [POOL_IDX_W-1:0]  pool_idx;
    logic                   pool_ok;
    logic                   slot_ok;
    logic [HEAD_W-1:0]      head_cur;
    logic                   hit;
    logic [LINK_ADDR_W-1:0] pool_base;
    logic [LINK_ADDR_W-1:0] rd_addr;
    logic [LINK_ADDR_W-1:0] wr_addr;
    logic                   push;
    logic                   rd_en;
    logic [HEAD_W-1:0]      link_rdata;
    logic [HEAD_W-1:0]      link_val;

    always_comb
    begin
        pool_idx  = POOL_IDX_W'(in_data.pool_id);
        pool_ok   = (32'(in_data.pool_id) < NUM_POOLS);
        slot_ok   = (32'(in_data.slot_index) < SLOTS_PER_POOL);
        head_cur  = head_reg[pool_idx];
        hit       = pool_ok && (32'(head_cur) < SLOTS_PER_POOL);
        pool_base = LINK_ADDR_W'(LINK_ADDR_W'(pool_idx) * LINK_ADDR_W'(SLOTS_PER_POOL));
        rd_addr   = pool_base + LINK_ADDR_W'(head_cur);
        wr_addr   = pool_base + LINK_ADDR_W'(in_data.slot_index);
        push      = cmd.accept_free && pool_ok && slot_ok;
        rd_en     = cmd.accept_alloc && hit;
        // a link never written since reset reads as its default, slot plus one
        link_val  = valid_q ? link_rdata : dflt_q;
    end

    ppfla_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_addr),
        .wdata (head_cur),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_POOLS; p++)
            begin
                head_reg[p] <= '0;
            end
            link_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                head_reg[pool_idx]      <= HEAD_W'(in_data.slot_index);
                link_valid_reg[wr_addr] <= 1'b1;
            end
            else if (cmd.finish_alloc && hit_q)
            begin
                head_reg[pool_q] <= link_val;
            end
            if (cmd.finish_alloc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_alloc)
        begin
            pool_q  <= pool_idx;
            hit_q   <= hit;
            head_q  <= head_cur;
            valid_q <= link_valid_reg[rd_addr];
            dflt_q  <= HEAD_W'(head_cur + 1'b1);
        end
        if (cmd.finish_alloc)
        begin
            if (hit_q)
            begin
                out_data_reg.status       <= STATUS_GRANTED;
                out_data_reg.granted_slot <= head_q[SLOT_FIELD_W-1:0];
            end
            else
            begin
                out_data_reg.status       <= STATUS_EMPTY;
                out_data_reg.granted_slot <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign sts.out_full = out_valid_reg;

endmodule

>>> hw/rtl/per_pool_free_list_allocator_core.sv
// Per-pool free list allocator: each pool keeps a head register and a linked
// list of free slots in one shared link memory. A free transfer writes the
// slot's link with the pool head and moves the head to the slot; it gives no
// result. An allocate transfer first lets the head register select the
// address for the link memory, and its registered read returns the next head;
// the result (granted slot, or the empty status with slot zero) is then
// loaded into the output register. An allocate waits in its link state while
// an earlier result is still held. The link memory needs no clearing pass after
// reset: a valid bit per link marks entries written since reset, and others
// read as slot plus one.
module per_pool_free_list_allocator_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ppfla_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ppfla_pkg::out_item_t out_data
);
    import ppfla_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    ppfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (in_data.command),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppfla_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> hw/rtl/ppfla_checker.sv
// port-level checks for the allocator, bound to the top level
module ppfla_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input ppfla_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input ppfla_pkg::out_item_t out_data
);
    import ppfla_pkg::*;

    // held result stays put until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_EMPTY) |-> (out_data.granted_slot == '0))
        else $error("failed allocation with nonzero slot");

    // a free never produces a result
    a_free_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.command == CMD_FREE) && !out_valid
        |=> !out_valid)
        else $error("result after free");

    // allocate holds off the next transfer while the link is read
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.command == CMD_ALLOC) |=> !in_ready)
        else $error("input ready during allocate");

endmodule

bind per_pool_free_list_allocator_core ppfla_checker u_ppfla_checker (.*);

>>> dv/ppfla_grant_checker.sv
`timescale 1ns / 100ps
// result checker for the per-pool free list allocator: tracks pool lists and compares grants
module ppfla_grant_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  ppfla_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  ppfla_pkg::out_item_t out_data,
    output int                   fail_count,
    output int                   grants_pending
);
    import ppfla_pkg::*;

    localparam logic [HEAD_W-1:0] LIST_END = HEAD_W'(SLOTS_PER_POOL);

    logic [HEAD_W-1:0] pool_head_q [NUM_POOLS];
    logic [HEAD_W-1:0] next_free_q [LINK_DEPTH];
    out_item_t         grant_queue [$];

    task automatic clear_lists();
        for (int p = 0; p < NUM_POOLS; p++)
        begin
            pool_head_q[p] = '0;
            for (int s = 0; s < SLOTS_PER_POOL; s++)
            begin
                next_free_q[p * SLOTS_PER_POOL + s] = HEAD_W'(s + 1);
            end
        end
        grant_queue.delete();
    endtask

    // free pushes at the head, allocate pops the head or reports an empty pool
    task automatic track_command(input in_item_t cmd_item);
        int                base;
        logic [HEAD_W-1:0] head_slot;
        out_item_t         grant;
        base = int'(cmd_item.pool_id) * SLOTS_PER_POOL;
        if (cmd_item.command == CMD_FREE)
        begin
            next_free_q[base + int'(cmd_item.slot_index)] = pool_head_q[cmd_item.pool_id];
            pool_head_q[cmd_item.pool_id] = HEAD_W'(cmd_item.slot_index);
        end
        else
        begin
            head_slot = pool_head_q[cmd_item.pool_id];
            if (head_slot >= LIST_END)
            begin
                grant.status       = STATUS_EMPTY;
                grant.granted_slot = '0;
            end
            else
            begin
                pool_head_q[cmd_item.pool_id] = next_free_q[base + int'(head_slot)];
                grant.status       = STATUS_GRANTED;
                grant.granted_slot = SLOT_FIELD_W'(head_slot);
            end
            grant_queue.push_back(grant);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        out_item_t want;
        if (!rst_n)
        begin
            clear_lists();
            fail_count     = 0;
            grants_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (grant_queue.size() == 0)
                begin
                    $error("unexpected result: status %0d granted_slot %0d",
                           out_data.status, out_data.granted_slot);
                    fail_count++;
                end
                else
                begin
                    want = grant_queue.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.granted_slot !== want.granted_slot)
                    begin
                        $error("granted_slot: expected %0d, actual %0d",
                               want.granted_slot, out_data.granted_slot);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                track_command(in_data);
            end
            grants_pending = grant_queue.size();
        end
    end

endmodule

>>> dv/per_pool_free_list_allocator_core_tb.sv
`timescale 1ns / 100ps
// testbench top for the per-pool free list allocator: command stimulus and verdict
module per_pool_free_list_allocator_core_tb;
    import ppfla_pkg::*;

    localparam int ITEM_TARGET  = 1550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 17;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int fail_count;
    int grants_pending;
    int cycle_count  = 0;
    int sent_count   = 0;
    int results_seen = 0;
    logic calm;

    // slots granted and not yet returned, per pool
    logic [SLOT_FIELD_W-1:0] held_slots [NUM_POOLS][$];
    logic [POOL_FIELD_W-1:0] alloc_pools [$];

    per_pool_free_list_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ppfla_grant_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .grants_pending (grants_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stretch with no idling on either side
    assign calm = (cycle_count >= 1500) && (cycle_count < 2500);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL per_pool_free_list_allocator_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin : collect_grants
        logic [POOL_FIELD_W-1:0] pool;
        if (rst_n && out_valid && out_ready)
        begin
            pool = alloc_pools.pop_front();
            results_seen++;
            if (out_data.status == STATUS_GRANTED)
            begin
                held_slots[pool].push_back(out_data.granted_slot);
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (results_seen == HOLD_AT)
            begin
                // long back-pressure so the block fills and stalls its input
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic offer(input cmd_e cmd, input logic [POOL_FIELD_W-1:0] pool,
                         input logic [SLOT_FIELD_W-1:0] slot);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid           = 1'b1;
        in_data.command    = cmd;
        in_data.pool_id    = pool;
        in_data.slot_index = slot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (cmd == CMD_ALLOC)
        begin
            alloc_pools.push_back(pool);
        end
        sent_count++;
        @(negedge clk);
    endtask

    task automatic return_slot(input logic [POOL_FIELD_W-1:0] pool, input bit pick_any);
        int                      idx;
        logic [SLOT_FIELD_W-1:0] slot;
        while (held_slots[pool].size() == 0)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        idx  = pick_any ? $urandom_range(0, held_slots[pool].size() - 1)
                        : held_slots[pool].size() - 1;
        slot = held_slots[pool][idx];
        held_slots[pool].delete(idx);
        offer(CMD_FREE, pool, slot);
    endtask

    initial
    begin : make_commands
        logic [POOL_FIELD_W-1:0] focus;
        logic [POOL_FIELD_W-1:0] pool;
        int                      alloc_pct;
        int                      burst;
        bit                      noisy;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every pool, slot field extremes, back-to-back pops and push then pop
        offer(CMD_ALLOC, 2'd0, 6'd0);
        offer(CMD_ALLOC, 2'd0, 6'd63);
        offer(CMD_ALLOC, 2'd1, 6'd42);
        offer(CMD_ALLOC, 2'd2, 6'd21);
        offer(CMD_ALLOC, 2'd3, 6'd63);
        offer(CMD_ALLOC, 2'd3, 6'd0);
        return_slot(2'd0, 1'b0);
        offer(CMD_ALLOC, 2'd0, 6'd63);
        return_slot(2'd3, 1'b0);
        return_slot(2'd3, 1'b0);
        offer(CMD_ALLOC, 2'd3, 6'd0);
        offer(CMD_ALLOC, 2'd3, 6'd63);
        return_slot(2'd2, 1'b0);
        offer(CMD_ALLOC, 2'd2, 6'd0);
        return_slot(2'd1, 1'b0);
        return_slot(2'd0, 1'b0);
        offer(CMD_ALLOC, 2'd1, 6'd63);
        offer(CMD_ALLOC, 2'd0, 6'd0);

        // run one pool dry, including requests on the empty pool
        repeat (70) offer(CMD_ALLOC, 2'd1, SLOT_FIELD_W'($urandom));

        // bursts focused on one pool; double frees only near the end of the run
        while (sent_count < ITEM_TARGET)
        begin
            focus = POOL_FIELD_W'($urandom_range(0, NUM_POOLS - 1));
            case ($urandom_range(0, 2))
                0:       alloc_pct = 90;
                1:       alloc_pct = 50;
                default: alloc_pct = 15;
            endcase
            burst = $urandom_range(10, 60);
            repeat (burst)
            begin
                pool  = ($urandom_range(0, 3) == 0) ?
                        POOL_FIELD_W'($urandom_range(0, NUM_POOLS - 1)) : focus;
                noisy = sent_count > (ITEM_TARGET * 85) / 100;
                if ($urandom_range(0, 99) < alloc_pct)
                begin
                    offer(CMD_ALLOC, pool, SLOT_FIELD_W'($urandom));
                end
                else if (noisy && $urandom_range(0, 99) < 30)
                begin
                    offer(CMD_FREE, pool, SLOT_FIELD_W'($urandom));
                end
                else if (held_slots[pool].size() > 0)
                begin
                    return_slot(pool, 1'b1);
                end
                else
                begin
                    offer(CMD_ALLOC, pool, SLOT_FIELD_W'($urandom));
                end
            end
        end
        in_valid = 1'b0;

        while (grants_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("PASS per_pool_free_list_allocator_core");
        end
        else
        begin
            $display("FAIL per_pool_free_list_allocator_core");
        end
        $finish;
    end

endmodule
